FILE: rtl/lcdseq_pkg.sv
`default_nettype none

package lcdseq_pkg;

  // kind of input item, carried on in_tuser
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_STAT_WR = 2'd1,
    OP_LCDC_WR = 2'd2,
    OP_LYC_WR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_t;

  localparam int BUDGET_W = 12;
  localparam int DELTA_W  = 13;

  // mode and line lengths in dot cycles
  localparam logic signed [DELTA_W-1:0] HBLANK_LEN    = 13'sd204;
  localparam logic signed [DELTA_W-1:0] VBLANK_LEN    = 13'sd456;
  localparam logic signed [DELTA_W-1:0] OAM_LEN       = 13'sd80;
  localparam logic signed [DELTA_W-1:0] XFER_LEN      = 13'sd172;
  localparam logic signed [DELTA_W-1:0] LAST_LINE_LEN = 13'sd4;
  localparam logic signed [DELTA_W-1:0] WRAP_LEN      = 13'sd452;
  localparam logic signed [BUDGET_W-1:0] ENABLE_BUDGET = 12'sd76;

  localparam logic [7:0] VBLANK_LINE  = 8'd144;
  localparam logic [7:0] LAST_LINE    = 8'd153;
  localparam logic [7:0] WRAP_LINE    = 8'd154;
  localparam logic [7:0] LINE_AFTER_0 = 8'd1;

  localparam int LCD_EN_BIT = 7;

  typedef struct packed {
    logic signed [BUDGET_W-1:0] budget;
    lcd_mode_t                  imode;
    logic [7:0]                 ly;
    logic [7:0]                 lyc;
    logic [6:0]                 stat;
    logic [7:0]                 ctrl;
    logic                       level;
  } timing_state_t;

  typedef struct packed {
    logic stat_irq;
    logic vblank_irq;
    logic hblank_start;
    logic line_end;
  } pulses_t;

  typedef struct packed {
    timing_state_t s;
    pulses_t       p;
  } step_t;

endpackage

`default_nettype wire

FILE: rtl/lcdseq_engine.sv
`default_nettype none

module lcdseq_engine
  import lcdseq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire op_t        op,
  input  wire logic [7:0] cycles,
  input  wire logic [7:0] write_data,
  output step_t           result
);

  timing_state_t state_r;

  function automatic logic signed [BUDGET_W-1:0] budget_add(
    input logic signed [BUDGET_W-1:0] b,
    input logic signed [DELTA_W-1:0]  d
  );
    logic signed [DELTA_W:0] sum;
    sum = {{2{b[BUDGET_W-1]}}, b} + {d[DELTA_W-1], d};
    if (sum > 14'sd2047) begin
      return 12'sd2047;
    end else if (sum < -14'sd2048) begin
      return -12'sd2048;
    end
    return sum[BUDGET_W-1:0];
  endfunction

  // re-evaluate the stat line level, pulse on a rising edge
  function automatic step_t line_update(input step_t x);
    step_t y;
    logic  src;
    y   = x;
    src = ((x.s.ly == x.s.lyc) && x.s.stat[6]) ||
          ((x.s.imode == MODE_HBLANK) && x.s.stat[3]) ||
          ((x.s.imode == MODE_OAM) && x.s.stat[5]) ||
          ((x.s.imode == MODE_VBLANK) && (x.s.stat[4] || x.s.stat[5]));
    if (src && !x.s.level) begin
      y.p.stat_irq = 1'b1;
    end
    y.s.level = src;
    return y;
  endfunction

  function automatic step_t coinc_check(input step_t x);
    step_t y;
    logic  now;
    y   = x;
    now = (x.s.ly == x.s.lyc);
    if (x.s.ctrl[LCD_EN_BIT] && (x.s.stat[2] != now)) begin
      y.s.stat[2] = now;
      y = line_update(y);
    end
    return y;
  endfunction

  function automatic step_t enter_mode(input step_t x, input lcd_mode_t m);
    step_t y;
    y = x;
    y.s.stat[1:0] = m;
    y.s.imode     = m;
    y = line_update(y);
    case (m)
      MODE_HBLANK: begin
        y.s.budget       = budget_add(y.s.budget, HBLANK_LEN);
        y.p.hblank_start = 1'b1;
      end
      MODE_VBLANK: begin
        y.s.budget     = budget_add(y.s.budget, VBLANK_LEN);
        y.p.vblank_irq = 1'b1;
      end
      MODE_OAM: y.s.budget = budget_add(y.s.budget, OAM_LEN);
      default:  y.s.budget = budget_add(y.s.budget, XFER_LEN);
    endcase
    return y;
  endfunction

  logic signed [DELTA_W-1:0] cyc_neg;
  step_t                     nxt;

  assign cyc_neg = 13'sd0 - $signed({5'b0, cycles});

  always_comb begin
    nxt.s = state_r;
    nxt.p = '0;
    if (step_en) begin
      case (op)
        OP_TICK: begin
          if (state_r.ctrl[LCD_EN_BIT]) begin
            nxt.s.budget = budget_add(state_r.budget, cyc_neg);
            if (nxt.s.budget <= 12'sd0) begin
              case (state_r.imode)
                MODE_HBLANK: begin
                  nxt.s.ly       = state_r.ly + 8'd1;
                  nxt            = coinc_check(nxt);
                  nxt.p.line_end = 1'b1;
                  nxt = enter_mode(nxt, (nxt.s.ly == VBLANK_LINE) ? MODE_VBLANK : MODE_OAM);
                end
                MODE_VBLANK: begin
                  nxt.s.ly = state_r.ly + 8'd1;
                  if (nxt.s.ly == LAST_LINE) begin
                    nxt.s.budget = budget_add(nxt.s.budget, LAST_LINE_LEN);
                    nxt          = coinc_check(nxt);
                  end else if (nxt.s.ly == WRAP_LINE) begin
                    nxt.s.budget = budget_add(nxt.s.budget, WRAP_LEN);
                    nxt.s.ly     = 8'd0;
                    nxt          = coinc_check(nxt);
                  end else if (nxt.s.ly == LINE_AFTER_0) begin
                    // the short line at zero is over: next frame starts
                    nxt.s.ly = 8'd0;
                    nxt      = enter_mode(nxt, MODE_OAM);
                  end else begin
                    nxt.s.budget = budget_add(nxt.s.budget, VBLANK_LEN);
                    nxt          = coinc_check(nxt);
                  end
                end
                MODE_OAM: nxt = enter_mode(nxt, MODE_XFER);
                default:  nxt = enter_mode(nxt, MODE_HBLANK);
              endcase
            end
          end
        end
        OP_STAT_WR: begin
          nxt.s.stat = {write_data[6:3], state_r.stat[2:0]};
          if (state_r.ctrl[LCD_EN_BIT]) begin
            nxt = coinc_check(nxt);
            nxt = line_update(nxt);
          end
        end
        OP_LCDC_WR: begin
          nxt.s.ctrl = write_data;
          if (state_r.ctrl[LCD_EN_BIT] && !write_data[LCD_EN_BIT]) begin
            nxt.s.ly        = 8'd0;
            nxt.s.stat[1:0] = 2'b00;
            nxt.s.imode     = MODE_HBLANK;
          end else if (!state_r.ctrl[LCD_EN_BIT] && write_data[LCD_EN_BIT]) begin
            nxt.s.budget = ENABLE_BUDGET;
            nxt.s.imode  = MODE_OAM;
            nxt          = coinc_check(nxt);
          end
        end
        default: begin
          nxt.s.lyc = write_data;
          nxt       = coinc_check(nxt);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step_en) begin
      state_r <= nxt.s;
    end
  end

  assign result = nxt;

  // ticks with the panel off leave the timing untouched
  a_off_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (op == OP_TICK) && !state_r.ctrl[LCD_EN_BIT] |=> $stable(state_r))
    else $error("tick changed state with lcd off");

  a_write_no_mode_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (op != OP_TICK) |->
      !nxt.p.vblank_irq && !nxt.p.hblank_start && !nxt.p.line_end)
    else $error("mode pulse on a register write");

  // the line can only rise through one of the stat enables
  a_stat_pulse_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    nxt.p.stat_irq |-> (nxt.s.stat[6:3] != 4'd0))
    else $error("stat pulse with no enable set");

endmodule

`default_nettype wire

FILE: rtl/lcd_mode_timing_sequencer.sv
`default_nettype none

// channel  | dir | tdata                                   | tuser
// in_      | in  | [7:0] cycles, [15:8] write_data          | [1:0] op
// out_     | out | [7:0] line_number, [14:8] stat_readback, | -
//          |     | [22:15] control_readback, [23] stat_irq, |
//          |     | [24] vblank_irq, [25] hblank_start,      |
//          |     | [26] line_end, [31:27] zero              |
//
// every item gives exactly one result, held in the result register
// one item per cycle is taken unless out_tready stalls; the timing state updates
// from the input register, through the step logic, into the result register
// in_tready falls only while both the input register and the result register
// hold items and out_tready is low
// synchronous active-low reset clears all timing state and both valid flags

module lcd_mode_timing_sequencer
  import lcdseq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // cycles, write_data
  input  wire logic [1:0]  in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // line_number, stat_readback, control_readback,
                                       // stat_irq, vblank_irq, hblank_start, line_end
);

  logic       in_v_r;
  op_t        in_op_r;
  logic [7:0] in_cyc_r;
  logic [7:0] in_data_r;

  logic        out_v_r;
  logic [31:0] out_data_r;

  logic  advance;
  logic  fire;
  step_t res;

  // the step runs when the result register is free or being emptied
  assign advance   = !out_v_r || out_tready;
  assign fire      = in_v_r && advance;
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= op_t'(in_tuser);
      in_cyc_r  <= in_tdata[7:0];
      in_data_r <= in_tdata[15:8];
    end
  end

  lcdseq_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (fire),
    .op         (in_op_r),
    .cycles     (in_cyc_r),
    .write_data (in_data_r),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {5'b0, res.p.line_end, res.p.hblank_start, res.p.vblank_irq,
                     res.p.stat_irq, res.s.ctrl, res.s.stat, res.s.ly};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("step without a result");

  a_vblank_at_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24] |-> (out_tdata[7:0] == VBLANK_LINE))
    else $error("vblank entered away from its line");

  a_hblank_mode_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[25] |-> (out_tdata[9:8] == MODE_HBLANK))
    else $error("hblank pulse with wrong mode bits");

  a_stalled_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(in_op_r) && $stable(in_cyc_r))
    else $error("input register lost an item");

endmodule

`default_nettype wire

FILE: bench/lcd_mode_timing_sequencer_tb.sv
`timescale 1ns / 1ps

module lcd_mode_timing_sequencer_tb;
  import lcdseq_pkg::*;

  // result item as it appears on out_tdata, msb first
  typedef struct packed {
    logic [4:0] pad;
    logic       line_end;
    logic       hblank_start;
    logic       vblank_irq;
    logic       stat_irq;
    logic [7:0] ctrl;
    logic [6:0] stat;
    logic [7:0] ly;
  } lcd_readback_t;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'h0000;   // cycles, write_data
  logic [1:0]  in_tuser = OP_TICK;    // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;             // line_number, stat_readback, control_readback,
                                      // stat_irq, vblank_irq, hblank_start, line_end

  lcd_mode_timing_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // shadow copy of the timing state, as it should be after reset
  int         budget = 0;
  lcd_mode_t  imode = MODE_HBLANK;
  logic [7:0] ly = 8'd0;
  logic [7:0] lyc = 8'd0;
  logic [6:0] stat = 7'd0;
  logic [7:0] ctrl = 8'd0;
  logic       irq_level = 1'b0;

  // pulses raised during the step being predicted
  logic pl_stat, pl_vblank, pl_hblank, pl_end;

  lcd_readback_t expected_readback[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit sender_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int sink_left = 0;

  // every addition to the budget clips at the 12-bit signed range
  function automatic void add_budget(int d);
    int v;
    v = budget + d;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    budget = v;
  endfunction

  // the stat line is a level, a pulse goes out only on its rising edge
  function automatic void update_irq_line();
    logic src;
    src = ((ly == lyc) && stat[6]) ||
          ((imode == MODE_HBLANK) && stat[3]) ||
          ((imode == MODE_OAM) && stat[5]) ||
          ((imode == MODE_VBLANK) && (stat[4] || stat[5]));
    if (src) begin
      if (!irq_level) begin
        irq_level = 1'b1;
        pl_stat = 1'b1;
      end
    end else begin
      irq_level = 1'b0;
    end
  endfunction

  // coincidence flag follows ly == lyc, only while the panel is on
  function automatic void recheck_match();
    logic now_eq;
    if (!ctrl[LCD_EN_BIT]) return;
    now_eq = (ly == lyc);
    if (stat[2] != now_eq) begin
      stat[2] = now_eq;
      update_irq_line();
    end
  endfunction

  function automatic void switch_mode(lcd_mode_t m);
    stat[1:0] = m;
    imode = m;
    update_irq_line();
    case (m)
      MODE_HBLANK: begin
        add_budget(int'(HBLANK_LEN));
        pl_hblank = 1'b1;
      end
      MODE_VBLANK: begin
        add_budget(int'(VBLANK_LEN));
        pl_vblank = 1'b1;
      end
      MODE_OAM:    add_budget(int'(OAM_LEN));
      default:     add_budget(int'(XFER_LEN));
    endcase
  endfunction

  function automatic void advance_dots(logic [7:0] n);
    if (!ctrl[LCD_EN_BIT]) return;
    add_budget(-int'(n));
    if (budget > 0) return;
    case (imode)
      MODE_HBLANK: begin
        ly = ly + 8'd1;
        recheck_match();
        pl_end = 1'b1;
        if (ly == VBLANK_LINE) switch_mode(MODE_VBLANK);
        else switch_mode(MODE_OAM);
      end
      MODE_VBLANK: begin
        ly = ly + 8'd1;
        if (ly == LAST_LINE) begin
          // short last line of the frame
          add_budget(int'(LAST_LINE_LEN));
          recheck_match();
        end else if (ly == WRAP_LINE) begin
          // ly already reads 0 for the rest of that line
          add_budget(int'(WRAP_LEN));
          ly = 8'd0;
          recheck_match();
        end else if (ly == LINE_AFTER_0) begin
          ly = 8'd0;
          switch_mode(MODE_OAM);
        end else begin
          add_budget(int'(VBLANK_LEN));
          recheck_match();
        end
      end
      MODE_OAM: switch_mode(MODE_XFER);
      default:  switch_mode(MODE_HBLANK);
    endcase
  endfunction

  function automatic lcd_readback_t predict_timing(op_t op, logic [7:0] n, logic [7:0] wd);
    lcd_readback_t r;
    logic was_on;
    pl_stat = 1'b0;
    pl_vblank = 1'b0;
    pl_hblank = 1'b0;
    pl_end = 1'b0;
    case (op)
      OP_TICK: advance_dots(n);
      OP_STAT_WR: begin
        // only the enable bits are writable
        stat = {wd[6:3], stat[2:0]};
        if (ctrl[LCD_EN_BIT]) begin
          recheck_match();
          update_irq_line();
        end
      end
      OP_LCDC_WR: begin
        was_on = ctrl[LCD_EN_BIT];
        ctrl = wd;
        if (was_on && !wd[LCD_EN_BIT]) begin
          // panel off: budget and line level are left alone
          ly = 8'd0;
          stat[1:0] = 2'b00;
          imode = MODE_HBLANK;
        end else if (!was_on && wd[LCD_EN_BIT]) begin
          // panel on: oam scan, but stat still reports mode 0
          budget = int'(ENABLE_BUDGET);
          imode = MODE_OAM;
          recheck_match();
        end
      end
      default: begin
        lyc = wd;
        recheck_match();
      end
    endcase
    r.pad = 5'd0;
    r.line_end = pl_end;
    r.hblank_start = pl_hblank;
    r.vblank_irq = pl_vblank;
    r.stat_irq = pl_stat;
    r.ctrl = ctrl;
    r.stat = stat;
    r.ly = ly;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input item; valid stays high into the next item when there is no gap
  task automatic issue_item(op_t op, logic [7:0] n, logic [7:0] wd);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {wd, n};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_readback.push_back(predict_timing(op, n, wd));
  endtask

  // valid drops first so the last item is not taken again while waiting
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (expected_readback.size() != 0) @(posedge clk);
  endtask

  // result side backpressure
  always @(posedge clk) begin
    if (sink_left == 0) sink_left = sink_stalls ? pick_gap() : 0;
    if (sink_left > 0) begin
      sink_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // every accepted result against the oldest prediction
  always @(posedge clk) begin : check_result
    lcd_readback_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_readback.size() == 0) begin
        $display("%0t unexpected result expected none actual %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = expected_readback.pop_front();
        compare_field("line_number", want.ly, got.ly);
        compare_field("stat_readback", want.stat, got.stat);
        compare_field("control_readback", want.ctrl, got.ctrl);
        compare_field("stat_irq", want.stat_irq, got.stat_irq);
        compare_field("vblank_irq", want.vblank_irq, got.vblank_irq);
        compare_field("hblank_start", want.hblank_start, got.hblank_start);
        compare_field("line_end", want.line_end, got.line_end);
        compare_field("pad", want.pad, got.pad);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL lcd_mode_timing_sequencer");
      $finish;
    end
  end

  // panel off: ticks do nothing, writes are only stored
  task automatic test_panel_off();
    issue_item(OP_TICK, 8'hFF, 8'h00);
    issue_item(OP_TICK, 8'h00, 8'hFF);
    issue_item(OP_STAT_WR, 8'h00, 8'hFF);
    issue_item(OP_LYC_WR, 8'h00, 8'hFF);
    issue_item(OP_LYC_WR, 8'h00, 8'h00);
    issue_item(OP_LCDC_WR, 8'h00, 8'h7F);
    issue_item(OP_TICK, 8'hAA, 8'h55);
  endtask

  // enable with coincidence, then walk oam -> transfer -> hblank -> next line
  task automatic test_mode_walk();
    issue_item(OP_LCDC_WR, 8'h00, 8'h80);
    issue_item(OP_TICK, 8'h00, 8'h00);
    issue_item(OP_TICK, 8'd76, 8'h00);
    issue_item(OP_TICK, 8'd171, 8'h00);
    issue_item(OP_TICK, 8'd1, 8'h00);
    issue_item(OP_TICK, 8'd204, 8'h00);
    issue_item(OP_STAT_WR, 8'h00, 8'h00);
    issue_item(OP_STAT_WR, 8'h00, 8'h78);
    issue_item(OP_LYC_WR, 8'h00, 8'h01);
    issue_item(OP_LYC_WR, 8'h00, 8'h80);
    issue_item(OP_TICK, 8'hFF, 8'h00);
  endtask

  // panel off mid line, back on with every control bit, off again
  task automatic test_panel_toggle();
    issue_item(OP_LCDC_WR, 8'h00, 8'h00);
    issue_item(OP_LCDC_WR, 8'h00, 8'hFF);
    issue_item(OP_TICK, 8'hFF, 8'h00);
    issue_item(OP_LCDC_WR, 8'h00, 8'h00);
  endtask

  // panel kept on, long ticks so that whole frames with vblank go by
  task automatic test_frame_walk(int count);
    int r;
    issue_item(OP_LCDC_WR, 8'h00, 8'h80 | 8'($urandom));
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        // sender holds off until the pipe is empty
        wait_for_drain();
        sink_stalls = 1'b0;
      end
      if (i == (count * 3) / 4) sink_stalls = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 75) issue_item(OP_TICK, 8'($urandom_range(160, 255)), 8'($urandom));
      else if (r < 85) issue_item(OP_TICK, 8'($urandom), 8'($urandom));
      else if (r < 92) issue_item(OP_STAT_WR, 8'($urandom), 8'($urandom));
      else if (r < 98) begin
        if ($urandom_range(0, 9) < 9)
          issue_item(OP_LYC_WR, 8'($urandom), 8'($urandom_range(0, 153)));
        else
          issue_item(OP_LYC_WR, 8'($urandom), 8'($urandom));
      end else begin
        issue_item(OP_LCDC_WR, 8'($urandom), 8'h80 | 8'($urandom));
      end
    end
  endtask

  // anything goes, the panel is switched on and off often
  task automatic test_mixed_noise(int count);
    int r;
    sender_gaps = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) sender_gaps = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 55) issue_item(OP_TICK, 8'($urandom), 8'($urandom));
      else if (r < 70) issue_item(OP_STAT_WR, 8'($urandom), 8'($urandom));
      else if (r < 80) issue_item(OP_LCDC_WR, 8'($urandom), 8'($urandom));
      else issue_item(OP_LYC_WR, 8'($urandom), 8'($urandom_range(0, 3)));
    end
  endtask

  // small ticks, so the budget lands on zero and just below it
  task automatic test_fine_steps(int count);
    int r;
    issue_item(OP_LCDC_WR, 8'h00, 8'h00);
    issue_item(OP_LCDC_WR, 8'h00, 8'h80 | 8'($urandom));
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85) issue_item(OP_TICK, 8'($urandom_range(0, 12)), 8'($urandom));
      else if (r < 93) issue_item(OP_STAT_WR, 8'($urandom), 8'($urandom));
      else issue_item(OP_LYC_WR, 8'($urandom), 8'($urandom_range(0, 2)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_panel_off();
    test_mode_walk();
    test_panel_toggle();
    test_frame_walk(500);
    test_mixed_noise(300);
    test_fine_steps(150);

    in_tvalid <= 1'b0;
    wait_for_drain();
    // then wait for anything stray out of the pipe
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS lcd_mode_timing_sequencer");
    end else begin
      $display("FAIL lcd_mode_timing_sequencer");
    end
    $finish;
  end

endmodule
